FILE: sv/mcys_pkg.sv
// ----------------------------------------------------------------------------
// mcys_pkg
// Shared widths, register indexes and the tangent table for the till yield
// stress block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcys_pkg;

    localparam int TAN_TABLE_DEPTH = 1024;
    localparam int TAN_ENTRIES     = TAN_TABLE_DEPTH + 1;
    localparam int ADDR_W          = $clog2(TAN_ENTRIES);

    localparam int CLASS_W = 2;
    localparam int H_W     = 16;
    localparam int W_W     = 16;
    localparam int PHI_W   = 15;
    localparam int TAU_W   = 28;
    localparam int TAN_W   = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WMAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OB    = 3'd5;

    localparam logic [CLASS_W-1:0] CLASS_OCEAN = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_BARE  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_ICE   = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_UNUSED = 2'd3;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef logic [TAN_W-1:0] t_tan_tab [TAN_ENTRIES];

    // restoring long division, table build only
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tan(x) in Q.16 for x in Q30, truncated Taylor terms
    function automatic logic [TAN_W-1:0] tan_q16(input logic [63:0] x);
        logic [63:0] st;
        logic [63:0] ss;
        logic [63:0] ct;
        logic [63:0] cs;
        st = x;
        ss = x;
        ct = Q30_ONE;
        cs = Q30_ONE;
        for (int n = 1; n <= 12; n++) begin
            st = (st * x) >> 30;
            st = udiv64((st * x) >> 30, 64'(2 * n) * 64'(2 * n + 1));
            ct = (ct * x) >> 30;
            ct = udiv64((ct * x) >> 30, 64'(2 * n - 1) * 64'(2 * n));
            if ((n & 1) == 1) begin
                ss = ss - st;
                cs = cs - ct;
            end else begin
                ss = ss + st;
                cs = cs + ct;
            end
        end
        if (cs == 64'd0) begin
            cs = 64'd1;
        end
        return TAN_W'(udiv64((ss << 16) + (cs >> 1), cs));
    endfunction

    function automatic t_tan_tab build_tan_tab();
        t_tan_tab    tab;
        logic [63:0] den;
        logic [63:0] theta;
        den = 64'd180 * 64'(TAN_TABLE_DEPTH);
        for (int k = 0; k < TAN_ENTRIES; k++) begin
            theta = udiv64(64'(k) * 64'd70 * PI_Q30 + (den >> 1), den);
            tab[k] = tan_q16(theta);
        end
        return tab;
    endfunction

    localparam t_tan_tab TAN_TAB = build_tan_tab();

endpackage

`default_nettype wire

FILE: sv/mcys_if.sv
// ----------------------------------------------------------------------------
// mcys_if
// Item, result and configuration channels of the till yield stress block.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcys_in_if import mcys_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] cell_class;
    logic [H_W-1:0]     ice_height;
    logic [W_W-1:0]     water_thickness;
    logic [PHI_W-1:0]   friction_angle;

    modport source (output valid, cell_class, ice_height, water_thickness,
                    friction_angle, input ready);
    modport sink   (input valid, cell_class, ice_height, water_thickness,
                    friction_angle, output ready);
endinterface

interface mcys_out_if import mcys_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TAU_W-1:0] yield_stress;
    logic             water_over_limit;

    modport source (output valid, yield_stress, water_over_limit, input ready);
    modport sink   (input valid, yield_stress, water_over_limit, output ready);
endinterface

interface mcys_cfg_if import mcys_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/mcys_ram.sv
// ----------------------------------------------------------------------------
// mcys_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcys_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire

FILE: sv/mohr_coulomb_yield_stress.sv
// ----------------------------------------------------------------------------
// mohr_coulomb_yield_stress
// Till yield stress per grid cell: cohesion plus effective pressure times the
// tangent of the friction angle; ocean, ice-free and mode-0 cells are fixed.
// ----------------------------------------------------------------------------
// One item per cycle while the result side is ready.
// The pipe depth is set by the 2-bit-per-stage pore pressure divider.
// After reset the tangent RAM is filled, one entry a cycle, until all
// TAN_TABLE_DEPTH + 1 entries are written; no item is taken until then.
// Configuration resets to its defaults; write it only while no item is in flight.
`default_nettype none

module mohr_coulomb_yield_stress import mcys_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    mcys_in_if.sink   i_item,
    mcys_cfg_if.sink  i_cfg,
    mcys_out_if.source o_result
);

    localparam logic [PHI_W-1:0] ANGLE_FULL = 15'd17920;
    localparam int DIV_SHIFT = 40;
    localparam int RECIP_W   = 26;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'((64'd1 << DIV_SHIFT) / 64'(ANGLE_FULL));
    localparam int S_W   = $clog2(17920 * TAN_TABLE_DEPTH + 1);
    localparam int P_W   = 36;
    localparam int REM_W = 34;
    localparam int QB    = 18;
    localparam int V_W   = 34;
    localparam int NT_W  = P_W + TAN_W;

    localparam int DIV_FIRST  = 2;
    localparam int DIV_STAGES = QB / 2;
    localparam int ST_MUL = 1;
    localparam int ST_ANG = 2;
    localparam int ST_RAM = 3;
    localparam int ST_IQ  = 4;
    localparam int ST_IT  = 5;
    localparam int ST_PW  = DIV_FIRST + DIV_STAGES;
    localparam int ST_N   = ST_PW + 1;
    localparam int ST_NT  = ST_PW + 2;
    localparam int ST_OUT = ST_PW + 3;
    localparam int NST    = ST_OUT + 1;

    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_HIGH = 2'd1;
    localparam logic [1:0] RES_MC   = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              flag;
        logic [H_W-1:0]    h;
        logic [W_W-1:0]    wc;
        logic [W_W-1:0]    wmax;
        logic [16:0]       alpha;
        logic [S_W-1:0]    s;
        logic [P_W-1:0]    p;
        logic [REM_W-1:0]  rem;
        logic [QB-1:0]     quo;
        logic [ADDR_W-1:0] aq;
        logic [PHI_W-1:0]  af;
        logic [TAN_W-1:0]  lo;
        logic [V_W-1:0]    v;
        logic [TAN_W-1:0]  iq;
        logic [TAN_W-1:0]  t;
        logic [P_W-1:0]    n;
        logic [NT_W-1:0]   nt;
        logic [TAU_W-1:0]  tau;
    } t_item;

    // configuration
    logic              r_mode;
    logic [TAU_W-1:0]  r_high;
    logic [19:0]       r_coh;
    logic [16:0]       r_alpha;
    logic [W_W-1:0]    r_wmax;
    logic [19:0]       r_ob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_high  <= 28'd1000000;
            r_coh   <= 20'd0;
            r_alpha <= 17'd62259;
            r_wmax  <= 16'd2000;
            r_ob    <= 20'd228531;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODE:  r_mode  <= i_cfg.data[0];
                REG_HIGH:  r_high  <= i_cfg.data[TAU_W-1:0];
                REG_COH:   r_coh   <= i_cfg.data[19:0];
                REG_ALPHA: r_alpha <= i_cfg.data[16:0];
                REG_WMAX:  r_wmax  <= i_cfg.data[W_W-1:0];
                REG_OB:    r_ob    <= i_cfg.data[19:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // tangent table fill
    logic              r_fill_done;
    logic [ADDR_W-1:0] r_fill_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_done <= 1'b0;
            r_fill_cnt  <= '0;
        end else if (!r_fill_done) begin
            if (r_fill_cnt == ADDR_W'(TAN_TABLE_DEPTH)) begin
                r_fill_done <= 1'b1;
            end else begin
                r_fill_cnt <= r_fill_cnt + 1'b1;
            end
        end
    end

    // pipeline
    logic        r_vld [NST];
    t_item       r_st  [NST];
    t_item       n_st  [NST];
    logic        en;
    logic        take;
    logic [TAN_W-1:0]  rd_lo;
    logic [TAN_W-1:0]  rd_hi;
    logic [ADDR_W-1:0] ra_lo;
    logic [ADDR_W-1:0] ra_hi;

    assign en            = !r_vld[NST-1] || o_result.ready;
    assign i_item.ready  = en && r_fill_done;
    assign take          = i_item.valid && i_item.ready;

    assign ra_lo = n_st[ST_ANG].aq;
    assign ra_hi = (n_st[ST_ANG].aq == ADDR_W'(TAN_TABLE_DEPTH)) ?
                   n_st[ST_ANG].aq : n_st[ST_ANG].aq + 1'b1;

    mcys_ram #(
        .WIDTH (TAN_W),
        .DEPTH (TAN_ENTRIES)
    ) u_tan_ram (
        .i_clk    (i_clk),
        .i_we     (!r_fill_done),
        .i_waddr  (r_fill_cnt),
        .i_wdata  (TAN_TAB[r_fill_cnt]),
        .i_re     (en),
        .i_raddr0 (ra_lo),
        .i_raddr1 (ra_hi),
        .o_rdata0 (rd_lo),
        .o_rdata1 (rd_hi)
    );

    always_comb begin
        logic [CLASS_W-1:0]       cls;
        logic [W_W-1:0]           wm;
        logic [PHI_W-1:0]         phi;
        logic [S_W+RECIP_W-1:0]   aprod;
        logic [S_W-1:0]           ares;
        logic [V_W+RECIP_W-1:0]   vprod;
        logic [V_W-1:0]           vres;
        logic [TAN_W-1:0]         hi;
        logic [REM_W-1:0]         dsh;
        logic [P_W+QB-1:0]        pr;
        logic [NT_W:0]            ntr;
        logic [31:0]              sum;
        int                       k;

        // capture
        n_st[0] = r_st[0];
        cls = (i_item.cell_class == CLASS_UNUSED) ? CLASS_OCEAN : i_item.cell_class;
        if (!r_mode) begin
            n_st[0].kind = (cls != CLASS_OCEAN) ? RES_HIGH : RES_ZERO;
        end else begin
            case (cls)
                CLASS_BARE: n_st[0].kind = RES_HIGH;
                CLASS_ICE:  n_st[0].kind = RES_MC;
                default:    n_st[0].kind = RES_ZERO;
            endcase
        end
        wm = (r_wmax == '0) ? W_W'(1) : r_wmax;
        n_st[0].wmax  = wm;
        n_st[0].flag  = (n_st[0].kind == RES_MC) && (i_item.water_thickness > wm);
        n_st[0].wc    = (i_item.water_thickness > wm) ? wm : i_item.water_thickness;
        n_st[0].h     = i_item.ice_height;
        n_st[0].alpha = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;
        phi = (i_item.friction_angle > ANGLE_FULL) ? ANGLE_FULL : i_item.friction_angle;
        n_st[0].s = S_W'(S_W'(phi) * S_W'(TAN_TABLE_DEPTH));

        for (int j = 1; j < NST; j++) begin
            n_st[j] = r_st[j-1];
        end

        // overburden, divider numerator, angle index estimate
        n_st[ST_MUL].p   = P_W'(r_st[0].h) * P_W'(r_ob);
        n_st[ST_MUL].rem = REM_W'(r_st[0].alpha) * REM_W'(r_st[0].wc);
        aprod = (S_W+RECIP_W)'(r_st[0].s) * (S_W+RECIP_W)'(DIV_RECIP);
        n_st[ST_MUL].aq = ADDR_W'(aprod >> DIV_SHIFT);

        // angle index correction
        ares = r_st[ST_ANG-1].s - S_W'(S_W'(r_st[ST_ANG-1].aq) * S_W'(ANGLE_FULL));
        if (ares >= S_W'(ANGLE_FULL)) begin
            n_st[ST_ANG].aq = r_st[ST_ANG-1].aq + 1'b1;
            ares = ares - S_W'(ANGLE_FULL);
        end
        n_st[ST_ANG].af = PHI_W'(ares);

        // table read data
        hi = (rd_hi < rd_lo) ? rd_lo : rd_hi;
        n_st[ST_RAM].lo = rd_lo;
        n_st[ST_RAM].v  = V_W'(V_W'(hi - rd_lo) * V_W'(r_st[ST_RAM-1].af))
                        + V_W'(ANGLE_FULL >> 1);

        // interpolation quotient
        vprod = (V_W+RECIP_W)'(r_st[ST_IQ-1].v) * (V_W+RECIP_W)'(DIV_RECIP);
        n_st[ST_IQ].iq = TAN_W'(vprod >> DIV_SHIFT);

        vres = r_st[ST_IT-1].v - V_W'(V_W'(r_st[ST_IT-1].iq) * V_W'(ANGLE_FULL));
        n_st[ST_IT].t = r_st[ST_IT-1].lo + r_st[ST_IT-1].iq
                      + ((vres >= V_W'(ANGLE_FULL)) ? TAN_W'(1) : TAN_W'(0));

        // pore pressure fraction, two quotient bits a stage
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                n_st[DIV_FIRST].quo = '0;
            end
            for (int b = 0; b < 2; b++) begin
                k = QB - 1 - 2 * j - b;
                dsh = REM_W'(r_st[DIV_FIRST+j-1].wmax) << k;
                if (n_st[DIV_FIRST+j].rem >= dsh) begin
                    n_st[DIV_FIRST+j].rem = n_st[DIV_FIRST+j].rem - dsh;
                    n_st[DIV_FIRST+j].quo[k] = 1'b1;
                end
            end
        end

        // effective pressure and stress
        pr = (P_W+QB)'(r_st[ST_PW-1].p) * (P_W+QB)'(r_st[ST_PW-1].quo);
        n_st[ST_PW].n = P_W'(pr >> 16);
        n_st[ST_N].n  = r_st[ST_N-1].p - r_st[ST_N-1].n;
        n_st[ST_NT].nt = NT_W'(r_st[ST_NT-1].n) * NT_W'(r_st[ST_NT-1].t);

        ntr = (NT_W+1)'(r_st[ST_OUT-1].nt) + (NT_W+1)'(1 << 23);
        sum = 32'(r_coh) + 32'(ntr >> 24);
        case (r_st[ST_OUT-1].kind)
            RES_HIGH: n_st[ST_OUT].tau = r_high;
            RES_MC:   n_st[ST_OUT].tau = (sum > 32'(28'hFFFFFFF)) ? 28'hFFFFFFF :
                                         TAU_W'(sum);
            default:  n_st[ST_OUT].tau = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NST; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= take;
            for (int j = 1; j < NST; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NST; j++) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_result.valid            = r_vld[NST-1];
    assign o_result.yield_stress     = r_st[NST-1].tau;
    assign o_result.water_over_limit = r_st[NST-1].flag;

endmodule

`default_nettype wire
